### rtl/v3alu_pkg.sv
// Package for the three-component vector ALU.
// Holds the operation codes and error codes; no dependencies.
package v3alu_pkg;

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_SUB   = 4'd1,
        FN_CROSS = 4'd2,
        FN_DOT   = 4'd3,
        FN_SCALE = 4'd4,
        FN_DIV   = 4'd5,
        FN_LENSQ = 4'd6,
        FN_LEN   = 4'd7,
        FN_NORM  = 4'd8,
        FN_GT    = 4'd9,
        FN_LT    = 4'd10,
        FN_EQ    = 4'd11
    } func_t;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DZ   = 2'd1;
    localparam logic [1:0] ERR_SAT  = 2'd2;
    localparam logic [1:0] ERR_RSVD = 2'd3;

endpackage

### rtl/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Carries an opaque side word alongside; no package dependencies.
module v3alu_sqrt #(
    parameter int WB     = 32,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2*WB-1:0]     in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [WB-1:0]       out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int RW = WB + 3;

    logic              valid_reg [WB];
    logic [RW-1:0]     rem_reg   [WB];
    logic [WB-1:0]     root_reg  [WB];
    logic [2*WB-1:0]   rad_reg   [WB];
    logic [SIDE_W-1:0] side_reg  [WB];

    logic [RW-1:0]     rem_next  [WB];
    logic [WB-1:0]     root_next [WB];
    logic [2*WB-1:0]   rad_next  [WB];

    always_comb
    begin
        logic [RW-1:0]   rem_in;
        logic [WB-1:0]   root_in;
        logic [2*WB-1:0] rad_in;
        logic [RW-1:0]   rem_sh;
        logic [RW-1:0]   trial;
        logic            ge;
        for (int k = 0; k < WB; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = in_rad;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            rem_sh       = {rem_in[RW-3:0], rad_in[2*WB-1 -: 2]};
            trial        = {1'b0, root_in, 2'b01};
            ge           = (rem_sh >= trial);
            rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
            root_next[k] = {root_in[WB-2:0], ge};
            rad_next[k]  = {rad_in[2*WB-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WB; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < WB; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        for (int k = 1; k < WB; k++)
        begin
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < WB; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            rad_reg[k]  <= rad_next[k];
        end
    end

    assign out_valid = valid_reg[WB-1];
    assign out_root  = root_reg[WB-1];
    assign out_side  = side_reg[WB-1];

endmodule

### rtl/v3alu_div.sv
// Pipelined restoring divider: three dividends over one shared divisor,
// one quotient bit per stage. Carries an opaque side word; no package use.
module v3alu_div #(
    parameter int WB        = 32,
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [WB-1:0]                     in_den,
    input  logic [2:0][WB+FRAC_BITS-1:0]      in_num,
    input  logic [SIDE_W-1:0]                 in_side,
    output logic                              out_valid,
    output logic [2:0][WB+FRAC_BITS-1:0]      out_quot,
    output logic [SIDE_W-1:0]                 out_side
);

    localparam int N = WB + FRAC_BITS;

    logic                 valid_reg [N];
    logic [WB-1:0]        den_reg   [N];
    logic [2:0][WB:0]     rem_reg   [N];
    logic [2:0][N-1:0]    work_reg  [N];
    logic [SIDE_W-1:0]    side_reg  [N];

    logic [2:0][WB:0]     rem_next  [N];
    logic [2:0][N-1:0]    work_next [N];

    always_comb
    begin
        logic [WB-1:0]     den_in;
        logic [2:0][WB:0]  rem_in;
        logic [2:0][N-1:0] work_in;
        logic [WB:0]       rem_sh;
        logic              ge;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                den_in  = in_den;
                rem_in  = '0;
                work_in = in_num;
            end
            else
            begin
                den_in  = den_reg[k-1];
                rem_in  = rem_reg[k-1];
                work_in = work_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                rem_sh            = {rem_in[i][WB-1:0], work_in[i][N-1]};
                ge                = (rem_sh >= {1'b0, den_in});
                rem_next[k][i]    = ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
                work_next[k][i]   = {work_in[i][N-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k < N; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0]  <= in_den;
        side_reg[0] <= in_side;
        for (int k = 1; k < N; k++)
        begin
            den_reg[k]  <= den_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
        for (int k = 0; k < N; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            work_reg[k] <= work_next[k];
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_quot  = work_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

### rtl/vector3_alu.sv
// Three-component vector ALU on signed fixed-point words, top level.
// Depends on v3alu_pkg, v3alu_sqrt and v3alu_div.
//
// One item is taken on every cycle in which start is high; busy is always
// low. Every item passes the same pipeline and gives exactly one result,
// in input order, marked by a one-cycle done pulse. The pipeline runs
// through the operand and product stage, the sum and saturation stage, the
// square-root pipeline, one root bit per stage (WB is WORD_BITS capped at
// 32), the divider pipeline, one quotient bit per stage, and the output
// register. The results must be taken as they appear.
module vector3_alu #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         func,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar_in,
    output logic               done,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [31:0] res_z,
    output logic signed [31:0] res_scalar,
    output logic               res_flag,
    output logic [1:0]         err_code
);

    localparam int WB = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam int PW = 2 * WB;
    localparam int N  = WB + FRAC_BITS;
    localparam int EW = (2 * WB + 2 > N + 1) ? 2 * WB + 2 : N + 1;

    typedef struct packed {
        v3alu_pkg::func_t   func;
        logic [WB-1:0]      rx;
        logic [WB-1:0]      ry;
        logic [WB-1:0]      rz;
        logic [WB-1:0]      rs;
        logic               flag;
        logic               hit;
        logic [WB-1:0]      ax;
        logic [WB-1:0]      ay;
        logic [WB-1:0]      az;
        logic [WB-1:0]      s;
    } side_t;

    typedef struct packed {
        v3alu_pkg::func_t   func;
        logic [WB-1:0]      rx;
        logic [WB-1:0]      ry;
        logic [WB-1:0]      rz;
        logic [WB-1:0]      rs;
        logic               flag;
        logic               hit;
        logic [2:0]         neg;
        logic               zero_err;
    } side2_t;

    localparam int SIDE_W  = $bits(side_t);
    localparam int SIDE2_W = $bits(side2_t);

    function automatic logic [WB:0] sat_fn(input logic signed [EW-1:0] v);
        logic hit;
        hit = !((&v[EW-1:WB-1]) || !(|v[EW-1:WB-1]));
        if (hit)
        begin
            return v[EW-1] ? {1'b1, 1'b1, {(WB-1){1'b0}}}
                           : {1'b1, 1'b0, {(WB-1){1'b1}}};
        end
        return {1'b0, v[WB-1:0]};
    endfunction

    function automatic logic [WB-1:0] mag_fn(input logic [WB-1:0] v);
        return v[WB-1] ? (~v + 1'b1) : v;
    endfunction

    assign busy = 1'b0;

    // stage 1: operand select and products
    logic signed [WB-1:0] in_a [3];
    logic signed [WB-1:0] in_b [3];
    logic signed [WB-1:0] in_s;
    logic signed [WB-1:0] mul_a [6];
    logic signed [WB-1:0] mul_b [6];
    logic signed [PW-1:0] prod_next [6];
    v3alu_pkg::func_t     in_func;

    assign in_a[0] = signed'(a_x[WB-1:0]);
    assign in_a[1] = signed'(a_y[WB-1:0]);
    assign in_a[2] = signed'(a_z[WB-1:0]);
    assign in_b[0] = signed'(b_x[WB-1:0]);
    assign in_b[1] = signed'(b_y[WB-1:0]);
    assign in_b[2] = signed'(b_z[WB-1:0]);
    assign in_s    = signed'(scalar_in[WB-1:0]);
    assign in_func = v3alu_pkg::func_t'(func);

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end
        case (in_func)
            v3alu_pkg::FN_CROSS:
            begin
                mul_a[0] = in_a[1]; mul_b[0] = in_b[2];
                mul_a[1] = in_a[2]; mul_b[1] = in_b[1];
                mul_a[2] = in_a[2]; mul_b[2] = in_b[0];
                mul_a[3] = in_a[0]; mul_b[3] = in_b[2];
                mul_a[4] = in_a[0]; mul_b[4] = in_b[1];
                mul_a[5] = in_a[1]; mul_b[5] = in_b[0];
            end
            v3alu_pkg::FN_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[2*i] = in_a[i];
                    mul_b[2*i] = in_b[i];
                end
            end
            v3alu_pkg::FN_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[2*i] = in_a[i];
                    mul_b[2*i] = in_s;
                end
            end
            v3alu_pkg::FN_LENSQ, v3alu_pkg::FN_LEN, v3alu_pkg::FN_NORM,
            v3alu_pkg::FN_GT, v3alu_pkg::FN_LT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[2*i]   = in_a[i];
                    mul_b[2*i]   = in_a[i];
                    mul_a[2*i+1] = in_b[i];
                    mul_b[2*i+1] = in_b[i];
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            prod_next[i] = PW'(mul_a[i]) * PW'(mul_b[i]);
        end
    end

    logic                 s1_valid_reg;
    v3alu_pkg::func_t     s1_func_reg;
    logic signed [WB-1:0] s1_a_reg [3];
    logic signed [WB-1:0] s1_b_reg [3];
    logic signed [WB-1:0] s1_s_reg;
    logic signed [PW-1:0] s1_prod_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_func_reg <= in_func;
        s1_s_reg    <= in_s;
        for (int i = 0; i < 3; i++)
        begin
            s1_a_reg[i] <= in_a[i];
            s1_b_reg[i] <= in_b[i];
        end
        for (int i = 0; i < 6; i++)
        begin
            s1_prod_reg[i] <= prod_next[i];
        end
    end

    // stage 2: sums, rounding, saturation, comparisons
    side_t        side_next;
    logic [PW-1:0] sqa_next;

    always_comb
    begin
        logic signed [EW-1:0] sum_e [3];
        logic signed [EW-1:0] dif_e [3];
        logic signed [EW-1:0] crs_e [3];
        logic signed [EW-1:0] scl_e [3];
        logic signed [EW-1:0] dot_e;
        logic signed [EW-1:0] lsq_e;
        logic [PW-1:0]        sqb;
        logic [WB:0]          sv [3];
        logic [WB:0]          ss;
        sqa_next = PW'(unsigned'(s1_prod_reg[0])) + PW'(unsigned'(s1_prod_reg[2]))
                 + PW'(unsigned'(s1_prod_reg[4]));
        sqb      = PW'(unsigned'(s1_prod_reg[1])) + PW'(unsigned'(s1_prod_reg[3]))
                 + PW'(unsigned'(s1_prod_reg[5]));
        for (int i = 0; i < 3; i++)
        begin
            sum_e[i] = EW'(s1_a_reg[i]) + EW'(s1_b_reg[i]);
            dif_e[i] = EW'(s1_a_reg[i]) - EW'(s1_b_reg[i]);
            crs_e[i] = (EW'(s1_prod_reg[2*i]) - EW'(s1_prod_reg[2*i+1])) >>> FRAC_BITS;
            scl_e[i] = EW'(s1_prod_reg[2*i]) >>> FRAC_BITS;
            sv[i]    = '0;
        end
        dot_e = (EW'(s1_prod_reg[0]) + EW'(s1_prod_reg[2]) + EW'(s1_prod_reg[4]))
                >>> FRAC_BITS;
        lsq_e = EW'(signed'({1'b0, sqa_next})) >>> FRAC_BITS;
        ss    = '0;

        side_next      = '0;
        side_next.func = s1_func_reg;
        side_next.ax   = s1_a_reg[0];
        side_next.ay   = s1_a_reg[1];
        side_next.az   = s1_a_reg[2];
        side_next.s    = s1_s_reg;
        case (s1_func_reg)
            v3alu_pkg::FN_ADD:
            begin
                for (int i = 0; i < 3; i++) sv[i] = sat_fn(sum_e[i]);
            end
            v3alu_pkg::FN_SUB:
            begin
                for (int i = 0; i < 3; i++) sv[i] = sat_fn(dif_e[i]);
            end
            v3alu_pkg::FN_CROSS:
            begin
                for (int i = 0; i < 3; i++) sv[i] = sat_fn(crs_e[i]);
            end
            v3alu_pkg::FN_SCALE:
            begin
                for (int i = 0; i < 3; i++) sv[i] = sat_fn(scl_e[i]);
            end
            v3alu_pkg::FN_DOT:   ss = sat_fn(dot_e);
            v3alu_pkg::FN_LENSQ: ss = sat_fn(lsq_e);
            v3alu_pkg::FN_GT:    side_next.flag = (sqa_next > sqb);
            v3alu_pkg::FN_LT:    side_next.flag = (sqa_next < sqb);
            v3alu_pkg::FN_EQ:
            begin
                side_next.flag = (s1_a_reg[0] == s1_b_reg[0])
                              && (s1_a_reg[1] == s1_b_reg[1])
                              && (s1_a_reg[2] == s1_b_reg[2]);
            end
            default:
            begin
            end
        endcase
        side_next.rx  = sv[0][WB-1:0];
        side_next.ry  = sv[1][WB-1:0];
        side_next.rz  = sv[2][WB-1:0];
        side_next.rs  = ss[WB-1:0];
        side_next.hit = sv[0][WB] | sv[1][WB] | sv[2][WB] | ss[WB];
    end

    logic          s2_valid_reg;
    side_t         s2_side_reg;
    logic [PW-1:0] s2_sqa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= side_next;
        s2_sqa_reg  <= sqa_next;
    end

    // square root of |a|^2
    logic          sq_valid;
    logic [WB-1:0] sq_root;
    side_t         sq_side;

    v3alu_sqrt #(
        .WB     (WB),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_rad    (s2_sqa_reg),
        .in_side   (s2_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // divider feed
    logic [WB-1:0]        den;
    logic [2:0][N-1:0]    num;
    side2_t               side2_next;

    always_comb
    begin
        logic is_div;
        logic is_norm;
        is_div  = (sq_side.func == v3alu_pkg::FN_DIV);
        is_norm = (sq_side.func == v3alu_pkg::FN_NORM);
        den     = is_div ? mag_fn(sq_side.s) : sq_root;
        num[0]  = {mag_fn(sq_side.ax), {FRAC_BITS{1'b0}}};
        num[1]  = {mag_fn(sq_side.ay), {FRAC_BITS{1'b0}}};
        num[2]  = {mag_fn(sq_side.az), {FRAC_BITS{1'b0}}};

        side2_next.func   = sq_side.func;
        side2_next.rx     = sq_side.rx;
        side2_next.ry     = sq_side.ry;
        side2_next.rz     = sq_side.rz;
        side2_next.rs     = sq_side.rs;
        side2_next.flag   = sq_side.flag;
        side2_next.hit    = sq_side.hit;
        side2_next.neg[0] = sq_side.ax[WB-1] ^ (is_div & sq_side.s[WB-1]);
        side2_next.neg[1] = sq_side.ay[WB-1] ^ (is_div & sq_side.s[WB-1]);
        side2_next.neg[2] = sq_side.az[WB-1] ^ (is_div & sq_side.s[WB-1]);
        side2_next.zero_err = (is_div && (sq_side.s == '0))
                           || (is_norm && (sq_root == '0));
        if (sq_side.func == v3alu_pkg::FN_LEN)
        begin
            side2_next.rs  = sq_root[WB-1] ? {1'b0, {(WB-1){1'b1}}} : sq_root;
            side2_next.hit = sq_root[WB-1];
        end
    end

    logic              dv_valid;
    logic [2:0][N-1:0] dv_quot;
    side2_t            dv_side;

    v3alu_div #(
        .WB        (WB),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_den    (den),
        .in_num    (num),
        .in_side   (side2_next),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    // output stage: quotient sign, saturation, error code
    logic signed [WB-1:0] rv_next [3];
    logic signed [WB-1:0] rs_next;
    logic                 flag_next;
    logic [1:0]           err_next;

    always_comb
    begin
        logic signed [EW-1:0] q_e;
        logic [WB:0]          qs;
        logic                 hit;
        logic                 is_q;
        is_q = (dv_side.func == v3alu_pkg::FN_DIV)
            || (dv_side.func == v3alu_pkg::FN_NORM);
        hit  = dv_side.hit;
        rv_next[0] = dv_side.rx;
        rv_next[1] = dv_side.ry;
        rv_next[2] = dv_side.rz;
        for (int i = 0; i < 3; i++)
        begin
            q_e = EW'({1'b0, dv_quot[i]});
            if (dv_side.neg[i])
            begin
                q_e = -q_e;
            end
            qs = sat_fn(q_e);
            if (is_q)
            begin
                rv_next[i] = dv_side.zero_err ? '0 : qs[WB-1:0];
                hit        = hit | (qs[WB] & !dv_side.zero_err);
            end
        end
        rs_next   = dv_side.rs;
        flag_next = dv_side.flag;
        if (is_q && dv_side.zero_err)
        begin
            err_next = v3alu_pkg::ERR_DZ;
        end
        else if (hit)
        begin
            err_next = v3alu_pkg::ERR_SAT;
        end
        else
        begin
            err_next = v3alu_pkg::ERR_OK;
        end
    end

    logic               done_reg;
    logic signed [31:0] res_x_reg;
    logic signed [31:0] res_y_reg;
    logic signed [31:0] res_z_reg;
    logic signed [31:0] res_scalar_reg;
    logic               res_flag_reg;
    logic [1:0]         err_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_x_reg      <= 32'(rv_next[0]);
        res_y_reg      <= 32'(rv_next[1]);
        res_z_reg      <= 32'(rv_next[2]);
        res_scalar_reg <= 32'(rs_next);
        res_flag_reg   <= flag_next;
        err_code_reg   <= err_next;
    end

    assign done       = done_reg;
    assign res_x      = res_x_reg;
    assign res_y      = res_y_reg;
    assign res_z      = res_z_reg;
    assign res_scalar = res_scalar_reg;
    assign res_flag   = res_flag_reg;
    assign err_code   = err_code_reg;

`ifndef SYNTHESIS
    ap_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> err_code != v3alu_pkg::ERR_RSVD)
        else $error("reserved error code on a result transfer");

    ap_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && err_code == v3alu_pkg::ERR_DZ |->
            res_x == 0 && res_y == 0 && res_z == 0 && res_scalar == 0 && !res_flag)
        else $error("divide-by-zero result not cleared");

    ap_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && res_flag |->
            res_x == 0 && res_y == 0 && res_z == 0 && res_scalar == 0
            && err_code == v3alu_pkg::ERR_OK)
        else $error("comparison flag alongside arithmetic result");
`endif

endmodule

### sim/tb_top.sv
// Testbench for vector3_alu: random and directed vector operations checked
// against a fixed-point predictor held in a small scoreboard class.
// Depends on v3alu_pkg and the vector3_alu RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam int LATENCY = 83;

    typedef struct {
        logic [3:0]  fn;
        logic [31:0] ax, ay, az, bx, by, bz, s;
    } vec_op_t;

    typedef struct {
        logic [31:0] x, y, z, sc;
        logic        flag;
        logic [1:0]  err;
    } vec_res_t;

    class alu_scoreboard;
        vec_res_t pending[$];
        int errors;
        int checked;
        int fn_seen[16];
        bit sat_flag;

        function longint clamp(longint v);
            if (v > 64'sd2147483647)
            begin
                sat_flag = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                sat_flag = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function longint fl(longint v);
            return v >>> FB;
        endfunction

        // sums of products fit 64 bits only after splitting into whole and fraction
        function longint sum_prod(longint p1, longint p2, longint p3, int n);
            longint h, l, p[3];
            p[0] = p1; p[1] = p2; p[2] = p3;
            h = 0; l = 0;
            for (int i = 0; i < n; i++)
            begin
                h += fl(p[i]);
                l += p[i] - (fl(p[i]) <<< FB);
            end
            return clamp(h + fl(l));
        endfunction

        function longint xterm(longint p, longint q, longint r, longint t);
            longint h, l, m, n;
            m = p * q;
            n = r * t;
            h = fl(m) - fl(n);
            l = (m - (fl(m) <<< FB)) - (n - (fl(n) <<< FB));
            return clamp(h + fl(l));
        endfunction

        function logic [65:0] sumsq(longint x, longint y, longint z);
            logic [65:0] t;
            t = 66'(x * x) + 66'(y * y) + 66'(z * z);
            return t;
        endfunction

        function logic [63:0] root(logic [65:0] v);
            logic [65:0] r, b;
            r = 0;
            b = 66'd1 << 64;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r[63:0];
        endfunction

        function longint qdiv(longint a, longint d);
            return clamp((a <<< FB) / d);
        endfunction

        function void note_transfer(vec_op_t op);
            longint ax, ay, az, bx, by, bz, s, q;
            vec_res_t r;
            ax = longint'(signed'(op.ax)); ay = longint'(signed'(op.ay));
            az = longint'(signed'(op.az)); bx = longint'(signed'(op.bx));
            by = longint'(signed'(op.by)); bz = longint'(signed'(op.bz));
            s = longint'(signed'(op.s));
            r = '{default: '0};
            sat_flag = 0;
            fn_seen[op.fn]++;
            case (op.fn)
                v3alu_pkg::FN_ADD:
                begin
                    r.x = 32'(clamp(ax + bx));
                    r.y = 32'(clamp(ay + by));
                    r.z = 32'(clamp(az + bz));
                end
                v3alu_pkg::FN_SUB:
                begin
                    r.x = 32'(clamp(ax - bx));
                    r.y = 32'(clamp(ay - by));
                    r.z = 32'(clamp(az - bz));
                end
                v3alu_pkg::FN_CROSS:
                begin
                    r.x = 32'(xterm(ay, bz, az, by));
                    r.y = 32'(xterm(az, bx, ax, bz));
                    r.z = 32'(xterm(ax, by, ay, bx));
                end
                v3alu_pkg::FN_DOT: r.sc = 32'(sum_prod(ax * bx, ay * by, az * bz, 3));
                v3alu_pkg::FN_SCALE:
                begin
                    r.x = 32'(clamp(fl(ax * s)));
                    r.y = 32'(clamp(fl(ay * s)));
                    r.z = 32'(clamp(fl(az * s)));
                end
                v3alu_pkg::FN_DIV:
                begin
                    if (s == 0)
                        r.err = v3alu_pkg::ERR_DZ;
                    else
                    begin
                        r.x = 32'(qdiv(ax, s));
                        r.y = 32'(qdiv(ay, s));
                        r.z = 32'(qdiv(az, s));
                    end
                end
                v3alu_pkg::FN_LENSQ:
                begin
                    logic [65:0] t;
                    t = sumsq(ax, ay, az) >> FB;
                    if (t > 66'd2147483647)
                    begin
                        sat_flag = 1;
                        r.sc = 32'h7fffffff;
                    end
                    else
                        r.sc = t[31:0];
                end
                v3alu_pkg::FN_LEN:
                    r.sc = 32'(clamp(longint'(root(sumsq(ax, ay, az)))));
                v3alu_pkg::FN_NORM:
                begin
                    q = longint'(root(sumsq(ax, ay, az)));
                    if (q == 0)
                        r.err = v3alu_pkg::ERR_DZ;
                    else
                    begin
                        r.x = 32'(qdiv(ax, q));
                        r.y = 32'(qdiv(ay, q));
                        r.z = 32'(qdiv(az, q));
                    end
                end
                v3alu_pkg::FN_GT: r.flag = sumsq(ax, ay, az) > sumsq(bx, by, bz);
                v3alu_pkg::FN_LT: r.flag = sumsq(ax, ay, az) < sumsq(bx, by, bz);
                v3alu_pkg::FN_EQ: r.flag = (ax == bx) && (ay == by) && (az == bz);
                default: ;
            endcase
            if (r.err == v3alu_pkg::ERR_OK && sat_flag)
                r.err = v3alu_pkg::ERR_SAT;
            pending.push_back(r);
        endfunction

        function void check_result(vec_res_t got);
            vec_res_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $error("result with nothing outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) begin $error("res_x exp %h got %h", e.x, got.x); errors++; end
            if (got.y !== e.y) begin $error("res_y exp %h got %h", e.y, got.y); errors++; end
            if (got.z !== e.z) begin $error("res_z exp %h got %h", e.z, got.z); errors++; end
            if (got.sc !== e.sc)
            begin
                $error("res_scalar exp %h got %h", e.sc, got.sc);
                errors++;
            end
            if (got.flag !== e.flag)
            begin
                $error("res_flag exp %b got %b", e.flag, got.flag);
                errors++;
            end
            if (got.err !== e.err)
            begin
                $error("err_code exp %0d got %0d", e.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, done, res_flag;
    logic [3:0] func;
    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, scalar_in;
    logic signed [31:0] res_x, res_y, res_z, res_scalar;
    logic [1:0] err_code;

    alu_scoreboard sb;

    vector3_alu dut (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && start && !busy)
            sb.note_transfer('{func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in});

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result('{res_x, res_y, res_z, res_scalar, res_flag, err_code});

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            4: return 32'($signed($urandom_range(0, 512)) - 256);
            5: return 32'h00010000;
            default: return $urandom;
        endcase
    endfunction

    // hold the transfer until busy is low; start stays high on return
    task automatic issue(vec_op_t op);
        start <= 1;
        func <= op.fn;
        a_x <= op.ax; a_y <= op.ay; a_z <= op.az;
        b_x <= op.bx; b_y <= op.by; b_z <= op.bz;
        scalar_in <= op.s;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic pause();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            start <= 0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic vec_op_t rnd_op();
        vec_op_t op;
        op.fn = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
        op.ax = rnd_word(); op.ay = rnd_word(); op.az = rnd_word();
        if ($urandom_range(0, 5) == 0)
        begin
            op.bx = op.ax; op.by = op.ay; op.bz = op.az;
        end
        else
        begin
            op.bx = rnd_word(); op.by = rnd_word(); op.bz = rnd_word();
        end
        op.s = ($urandom_range(0, 7) == 0) ? 32'h0 : rnd_word();
        return op;
    endfunction

    localparam logic [31:0] MX = 32'h7fffffff;
    localparam logic [31:0] MN = 32'h80000000;
    localparam logic [31:0] ONE = 32'h00010000;

    initial
    begin
        int wait_cycles;
        sb = new();
        rst_n = 0; start = 0; func = v3alu_pkg::FN_ADD;
        a_x = 0; a_y = 0; a_z = 0; b_x = 0; b_y = 0; b_z = 0; scalar_in = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        issue('{v3alu_pkg::FN_ADD, MX, MN, ONE, MX, MN, ONE, 0});
        issue('{v3alu_pkg::FN_SUB, MX, MN, 0, MN, MX, 0, 0});
        issue('{v3alu_pkg::FN_CROSS, MX, MN, MX, MN, MX, MN, 0});
        issue('{v3alu_pkg::FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0});
        issue('{v3alu_pkg::FN_DOT, MN, MN, MN, MN, MN, MN, 0});
        issue('{v3alu_pkg::FN_DOT, ONE, 32'hffff0000, 3, 5, ONE, 32'hffffffff, 0});
        issue('{v3alu_pkg::FN_SCALE, MX, MN, ONE, 0, 0, 0, MN});
        issue('{v3alu_pkg::FN_SCALE, 32'hffffffff, 1, ONE, 0, 0, 0, 32'h8000});
        issue('{v3alu_pkg::FN_DIV, ONE, MN, MX, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_DIV, MX, MN, 32'hfffffffd, 0, 0, 0, 1});
        issue('{v3alu_pkg::FN_DIV, MN, 7, ONE, 0, 0, 0, 32'hffffffff});
        issue('{v3alu_pkg::FN_LENSQ, MN, MN, MN, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_LENSQ, 1, 32'hffffffff, 0, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_LEN, MN, MN, MN, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_LEN, ONE, 0, 0, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_NORM, 0, 0, 0, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_NORM, 1, 0, 0, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_NORM, MX, MN, 5, 0, 0, 0, 0});
        issue('{v3alu_pkg::FN_GT, MN, 0, 0, MX, 0, 0, 0});
        issue('{v3alu_pkg::FN_LT, MN, 0, 0, MX, 0, 0, 0});
        issue('{v3alu_pkg::FN_GT, 3, 4, 0, 0, 0, 5, 0});
        issue('{v3alu_pkg::FN_EQ, MX, MN, 1, MX, MN, 1, 0});
        issue('{v3alu_pkg::FN_EQ, MX, MN, 1, MX, MN, 0, 0});
        issue('{4'd15, MX, MX, MX, MX, MX, MX, MX});
        issue('{4'd12, 1, 1, 1, 1, 1, 1, 1});

        for (int i = 0; i < 700; i++)
        begin
            issue(rnd_op());
            pause();
        end
        start <= 0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 20 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d results across all twelve operations and unused codes;",
                 sb.checked);
        $display("add %0d, cross %0d, divide %0d, normalize %0d, eq %0d.",
                 sb.fn_seen[v3alu_pkg::FN_ADD], sb.fn_seen[v3alu_pkg::FN_CROSS],
                 sb.fn_seen[v3alu_pkg::FN_DIV], sb.fn_seen[v3alu_pkg::FN_NORM],
                 sb.fn_seen[v3alu_pkg::FN_EQ]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
